// File: rtl/cxr_pkg.sv
// Shared types, constants and key table for the chained XOR record codec.
// No dependencies; imported by every module of the block.
package cxr_pkg;

  localparam int unsigned KeyLen  = 10;
  localparam int unsigned NumSums = 4;
  localparam int unsigned SumIdxW = $clog2(NumSums);
  localparam int unsigned BurstW  = $clog2(NumSums + 1);
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] RecLenReset = 16'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode   = 2'd0,
    CfgRecLen = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    ModeEncrypt = 1'b0,
    ModeDecrypt = 1'b1
  } mode_e;

  typedef enum logic {
    KindData  = 1'b0,
    KindCheck = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       check_ok;
    logic       last;
  } cxr_res_t;

  typedef logic [NumSums-1:0][7:0] cxr_sums_t;

  function automatic logic [7:0] key_byte(input logic [3:0] phase);
    logic [7:0] k;
    case (phase)
      4'd0:    k = 8'd15;
      4'd1:    k = 8'd50;
      4'd2:    k = 8'd89;
      4'd3:    k = 8'd240;
      4'd4:    k = 8'd147;
      4'd5:    k = 8'd34;
      4'd6:    k = 8'd86;
      4'd7:    k = 8'd9;
      4'd8:    k = 8'd32;
      4'd9:    k = 8'd208;
      default: k = 8'd15;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/cxr_core.sv
// Record state, config registers and per-byte cipher/checksum datapath.
// Depends on cxr_pkg. Produces one result per accepted item plus a burst request.
module cxr_core import cxr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  output cxr_res_t            res_o,
  output logic                burst_o,
  output cxr_sums_t           sums_o
);

  mode_e       mode_q;
  logic [15:0] rec_len_q;

  logic [15:0] pos_q, pos_d;
  logic [3:0]  phase_q, phase_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  neg_q, neg_d;
  logic [7:0]  mul_q, mul_d;
  logic [7:0]  xor_q, xor_d;
  logic        mism_q, mism_d;
  logic        tail_q, tail_d;

  logic [3:0]  kp;
  logic [7:0]  key;
  logic [7:0]  xored;
  logic [7:0]  plain;
  logic [7:0]  cipher;
  logic [15:0] mul_full;
  logic [15:0] eff_len;
  logic        rec_end;
  logic [SumIdxW-1:0] tidx;
  logic [7:0]  expect_sum;
  cxr_sums_t   cur_sums;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeEncrypt;
      rec_len_q <= RecLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMode:   mode_q    <= mode_e'(cfg_data_i[0]);
        CfgRecLen: rec_len_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  assign kp       = (phase_q < 4'(KeyLen)) ? phase_q : 4'd0;
  assign key      = key_byte(kp);
  assign xored    = in_byte_i ^ key ^ prev_q;
  assign plain    = (mode_q == ModeEncrypt) ? in_byte_i : xored;
  assign cipher   = (mode_q == ModeEncrypt) ? xored : in_byte_i;
  assign mul_full = {8'd0, mul_q} * {8'd0, plain};
  assign eff_len  = (rec_len_q == 16'd0) ? 16'd1 : rec_len_q;
  assign rec_end  = ({1'b0, pos_q} + 17'd1) >= {1'b0, eff_len};
  assign tidx     = pos_q[SumIdxW-1:0];
  assign cur_sums = {xor_q, mul_q, neg_q, sum_q};
  assign expect_sum = cur_sums[tidx];

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    prev_d  = prev_q;
    sum_d   = sum_q;
    neg_d   = neg_q;
    mul_d   = mul_q;
    xor_d   = xor_q;
    mism_d  = mism_q;
    tail_d  = tail_q;
    burst_o = 1'b0;
    sums_o  = cur_sums;
    res_o   = '{out_byte: expect_sum, kind: KindCheck, check_ok: 1'b1, last: 1'b0};

    if (tail_q) begin
      // stored checksum byte: compare, then clear the record after the fourth
      mism_d         = mism_q | (in_byte_i != expect_sum);
      res_o.check_ok = ~mism_d;
      res_o.last     = (tidx == SumIdxW'(NumSums - 1));
      if (res_o.last) begin
        pos_d   = '0;
        phase_d = 4'd1;
        prev_d  = '0;
        sum_d   = '0;
        neg_d   = '0;
        mul_d   = 8'd1;
        xor_d   = '0;
        mism_d  = 1'b0;
        tail_d  = 1'b0;
      end else begin
        pos_d = pos_q + 16'd1;
      end
    end else begin
      prev_d  = cipher;
      sum_d   = sum_q + plain;
      neg_d   = neg_q - plain;
      mul_d   = mul_full[7:0] + 8'd1;
      xor_d   = xor_q ^ plain;
      phase_d = (kp == 4'(KeyLen - 1)) ? 4'd0 : kp + 4'd1;
      res_o.out_byte = (mode_q == ModeEncrypt) ? cipher : plain;
      res_o.kind     = KindData;
      res_o.check_ok = (mode_q == ModeEncrypt) ? 1'b1 : ~mism_q;
      sums_o = {xor_d, mul_d, neg_d, sum_d};
      if (rec_end) begin
        pos_d = '0;
        if (mode_q == ModeEncrypt) begin
          // hand the final sums to the emitter, then clear
          burst_o = 1'b1;
          phase_d = 4'd1;
          prev_d  = '0;
          sum_d   = '0;
          neg_d   = '0;
          mul_d   = 8'd1;
          xor_d   = '0;
          mism_d  = 1'b0;
        end else begin
          tail_d = 1'b1;
        end
      end else begin
        pos_d = pos_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= 4'd1;
      prev_q  <= '0;
      sum_q   <= '0;
      neg_q   <= '0;
      mul_q   <= 8'd1;
      xor_q   <= '0;
      mism_q  <= 1'b0;
      tail_q  <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      prev_q  <= prev_d;
      sum_q   <= sum_d;
      neg_q   <= neg_d;
      mul_q   <= mul_d;
      xor_q   <= xor_d;
      mism_q  <= mism_d;
      tail_q  <= tail_d;
    end
  end

endmodule

// File: rtl/cxr_emit.sv
// Output result register and checksum burst sequencer.
// Depends on cxr_pkg. Holds the input off while appended checksums drain.
module cxr_emit import cxr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cxr_res_t  res_i,
  input  logic      burst_i,
  input  cxr_sums_t sums_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cxr_res_t  out_res_o,
  output logic      busy_o
);

  logic              valid_q;
  cxr_res_t          res_q;
  cxr_sums_t         sums_q;
  logic [BurstW-1:0] left_q;
  logic              accept;
  logic              drain;
  logic [SumIdxW-1:0] sidx;

  assign busy_o      = (left_q != '0);
  assign drain       = valid_q & out_ready_i;
  assign in_ready_o  = (~valid_q | out_ready_i) & ~busy_o;
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign sidx        = SumIdxW'(BurstW'(NumSums) - left_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
    end else if (accept) begin
      valid_q <= 1'b1;
      left_q  <= burst_i ? BurstW'(NumSums) : '0;
    end else if (drain && busy_o) begin
      valid_q <= 1'b1;
      left_q  <= left_q - BurstW'(1);
    end else if (drain) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= res_i;
      sums_q <= sums_i;
    end else if (drain && busy_o) begin
      // advance to the next appended checksum item
      res_q <= '{out_byte: sums_q[sidx], kind: KindCheck, check_ok: 1'b1,
                 last: (left_q == BurstW'(1))};
    end
  end

endmodule

// File: rtl/chained_xor_record_codec_with_checksums.sv
// Top level of the chained XOR record codec: config port, core and emitter.
// Depends on cxr_pkg, cxr_core and cxr_emit.
//
// Takes one byte per clock while the output accepts and no checksum burst
// drains, and returns one result per byte through a single output register,
// so input and output stream at one item per cycle under those conditions.
// After the last data byte of a record in encrypt mode four checksum items
// follow (sum, negated sum, multiplicative, XOR); the input is held off while
// the checksum burst drains. In decrypt mode the four stored checksum bytes
// are accepted like data, one result each. Config is written through
// cfg_we_i/cfg_idx_i/cfg_data_i (0: mode, 1: record_length) while idle.
module chained_xor_record_codec_with_checksums import cxr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] in_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]          m_axis_tuser,   // [0] kind, [1] check_ok
  output logic                m_axis_tlast
);

  cxr_res_t  core_res;
  cxr_res_t  out_res;
  cxr_sums_t core_sums;
  logic      core_burst;
  logic      accept;
  logic      burst_busy;

  assign accept = s_axis_tvalid & s_axis_tready;

  cxr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_byte_i  (s_axis_tdata),
    .res_o      (core_res),
    .burst_o    (core_burst),
    .sums_o     (core_sums)
  );

  cxr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .res_i       (core_res),
    .burst_i     (core_burst),
    .sums_i      (core_sums),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res),
    .busy_o      (burst_busy)
  );

  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tuser = {out_res.check_ok, out_res.kind};
  assign m_axis_tlast = out_res.last;

  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_busy |-> !s_axis_tready)
    else $error("input accepted during checksum burst");

  a_last_is_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("last item is not a checksum item");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  a_burst_starts_encrypt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(burst_busy) |-> m_axis_tvalid && !m_axis_tuser[0] && m_axis_tuser[1])
    else $error("checksum burst not preceded by encrypt data item");

endmodule

// File: test/tb_top.sv
// Self-checking bench for the chained XOR record codec: directed and random byte streams,
// both modes, with an in-bench predictor of ciphertext, plaintext and checksums.
// Depends on cxr_pkg and chained_xor_record_codec_with_checksums.
`timescale 1ns / 100ps

import cxr_pkg::*;

class codec_scoreboard;
  mode_e       mode;
  logic [15:0] rec_len;
  logic [15:0] pos;
  logic [3:0]  phase;
  logic [7:0]  prev_ct;
  cxr_sums_t   sums;       // [0] sum, [1] negated sum, [2] multiplicative, [3] xor
  bit          bad;
  bit          tail;
  logic [7:0]  key_tab [KeyLen];
  cxr_res_t    expected_q [$];
  int          errors;

  function new();
    key_tab = '{8'd15, 8'd50, 8'd89, 8'd240, 8'd147, 8'd34, 8'd86, 8'd9, 8'd32, 8'd208};
    mode    = ModeEncrypt;
    rec_len = RecLenReset;
    errors  = 0;
    clear_record();
  endfunction

  function void clear_record();
    pos     = '0;
    phase   = 4'd1;
    prev_ct = '0;
    sums    = '0;
    sums[2] = 8'd1;
    bad     = 1'b0;
    tail    = 1'b0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void config_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgMode:   mode = mode_e'(data[0]);
      CfgRecLen: rec_len = data;
      default:   ;
    endcase
  endfunction

  function void push(logic [7:0] b, kind_e k, logic ok, logic lst);
    cxr_res_t r;
    r.out_byte = b;
    r.kind     = k;
    r.check_ok = ok;
    r.last     = lst;
    expected_q.push_back(r);
  endfunction

  function void note_input(logic [7:0] b);
    logic [1:0]  idx;
    logic [3:0]  kp;
    logic [7:0]  plain;
    logic [7:0]  ct;
    logic [16:0] eff_len;
    bit          enc;
    if (tail) begin
      // stored checksums: compare, report the computed one
      idx = pos[1:0];
      if (b != sums[idx]) bad = 1'b1;
      push(sums[idx], KindCheck, !bad, idx == 2'd3);
      if (idx == 2'd3) clear_record();
      else pos = pos + 16'd1;
      return;
    end
    kp  = (phase < KeyLen) ? phase : 4'd0;
    enc = (mode == ModeEncrypt);
    if (enc) begin
      plain = b;
      ct    = b ^ key_tab[kp] ^ prev_ct;
    end else begin
      ct    = b;
      plain = b ^ key_tab[kp] ^ prev_ct;
    end
    prev_ct = ct;
    sums[0] = sums[0] + plain;
    sums[1] = sums[1] - plain;
    sums[2] = sums[2] * plain + 8'd1;
    sums[3] = sums[3] ^ plain;
    phase   = (kp == 4'd9) ? 4'd0 : kp + 4'd1;
    push(enc ? ct : plain, KindData, enc ? 1'b1 : !bad, 1'b0);
    // zero length acts as one
    eff_len = (rec_len == 16'd0) ? 17'd1 : {1'b0, rec_len};
    if ({1'b0, pos} + 17'd1 >= eff_len) begin
      if (enc) begin
        for (int i = 0; i < NumSums; i++) push(sums[i], KindCheck, 1'b1, i == NumSums - 1);
        clear_record();
      end else begin
        tail = 1'b1;
        pos  = '0;
      end
    end else begin
      pos = pos + 16'd1;
    end
  endfunction

  function void check_result(logic [7:0] data, logic [1:0] user, logic lst);
    cxr_res_t e;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: byte %h user %b last %b", data, user, lst);
      return;
    end
    e = expected_q.pop_front();
    if (data !== e.out_byte || user[0] !== e.kind || user[1] !== e.check_ok
        || lst !== e.last) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: expected byte %h kind %b ok %b last %b, ",
                  "got byte %h kind %b ok %b last %b"},
                 e.out_byte, e.kind, e.check_ok, e.last, data, user[0], user[1], lst);
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned ItemTarget = 380;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgMode;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  codec_scoreboard sb = new();
  int unsigned     cycle_cnt = 0;
  int unsigned     items_sent = 0;
  int              rdy_hold = 0;
  bit              burst_mode = 1'b0;

  chained_xor_record_codec_with_checksums dut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: mostly ready, short stalls, now and then a long one
  always @(posedge clk_i) begin
    int r;
    if (rdy_hold > 0) begin
      rdy_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_axis_tready <= 1'b1;
        rdy_hold = $urandom_range(0, 12);
      end else if (r < 66) begin
        m_axis_tready <= 1'b1;
        rdy_hold = $urandom_range(40, 80);
      end else if (r < 93) begin
        m_axis_tready <= 1'b0;
        rdy_hold = $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        rdy_hold = $urandom_range(8, 25);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.config_write(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(b);
    items_sent++;
    if (!burst_mode) begin
      r = $urandom_range(0, 99);
      if (r >= 60) begin
        s_axis_tvalid <= 1'b0;
        repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 30)) @(posedge clk_i);
      end
    end
  endtask

  // hold the sender until every expected item is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] good_sum();
    return sb.sums[sb.pos[1:0]];
  endfunction

  function automatic logic [7:0] next_byte();
    int r;
    r = $urandom_range(0, 99);
    if (sb.tail) begin
      if (r < 92) return good_sum();
      if (r < 96) return good_sum() ^ (8'd1 << $urandom_range(0, 7));
      return 8'($urandom);
    end
    if (r < 5) return 8'h00;
    if (r < 10) return 8'hFF;
    return 8'($urandom);
  endfunction

  initial begin
    logic [15:0] len_val;
    logic [15:0] mode_val;
    int          r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default setup: encrypt, long record, left open
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();
    // zero length closes the open record at once; spare indexes do nothing
    cfg_write(CfgRecLen, 16'd0);
    cfg_write(CfgSpareA, 16'hFFFF);
    cfg_write(CfgSpareB, 16'hFFFF);
    send_byte(8'h7F);
    send_byte(8'hFE);
    drain();
    // decrypt with matching checksums
    cfg_write(CfgMode, 16'(ModeDecrypt));
    cfg_write(CfgRecLen, 16'd2);
    send_byte(8'hAA);
    send_byte(8'h55);
    repeat (4) send_byte(good_sum());
    drain();
    // decrypt with a bad first checksum
    cfg_write(CfgRecLen, 16'd1);
    send_byte(8'h00);
    send_byte(good_sum() ^ 8'hFF);
    repeat (3) send_byte(good_sum());
    drain();
    // mode and length changed in the middle of a record
    cfg_write(CfgRecLen, 16'd3);
    send_byte(8'h81);
    drain();
    cfg_write(CfgMode, 16'(ModeEncrypt));
    cfg_write(CfgRecLen, 16'd2);
    send_byte(8'h18);
    drain();
    // stored checksums keep going after a switch to encrypt
    cfg_write(CfgMode, 16'(ModeDecrypt));
    cfg_write(CfgRecLen, 16'd1);
    send_byte(8'hC3);
    drain();
    cfg_write(CfgMode, 16'(ModeEncrypt));
    repeat (4) send_byte(good_sum());
    drain();
    // longest length, then cut short
    cfg_write(CfgRecLen, 16'hFFFF);
    send_byte(8'h3C);
    send_byte(8'hE7);
    drain();
    cfg_write(CfgRecLen, 16'd1);
    send_byte(8'h5A);

    while (items_sent < ItemTarget) begin
      drain();
      if ($urandom_range(0, 99) < 75) begin
        mode_val    = 16'($urandom);
        mode_val[0] = 1'($urandom_range(0, 1));
        cfg_write(CfgMode, mode_val);
      end
      r = $urandom_range(0, 99);
      if (r < 55) len_val = 16'($urandom_range(1, 6));
      else if (r < 80) len_val = 16'($urandom_range(7, 20));
      else if (r < 88) len_val = 16'($urandom_range(21, 64));
      else if (r < 94) len_val = 16'd0;
      else len_val = 16'hFFFF;
      if ($urandom_range(0, 99) < 85) cfg_write(CfgRecLen, len_val);
      if ($urandom_range(0, 99) < 8)
        cfg_write($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, 16'($urandom));
      burst_mode = ($urandom_range(0, 99) < 25);
      repeat ($urandom_range(1, 45)) send_byte(next_byte());
    end

    burst_mode = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: chained_xor_record_codec_with_checksums.f
rtl/cxr_pkg.sv
rtl/cxr_core.sv
rtl/cxr_emit.sv
rtl/chained_xor_record_codec_with_checksums.sv
test/tb_top.sv
